// ===== rtl/cwm_pkg.sv =====
// ----------------------------------------------------------------------------
// cwm_pkg
// Shared constants and types for the clipped-window median filter.
// ----------------------------------------------------------------------------
package cwm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int ROW_W      = 12;  // row counters, rows up to 4096
  localparam int OUT_COL_W  = 10;
  localparam int RAD_W      = 3;   // effective radius, up to 3 (2-bit config field)
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_WID_W  = 11;
  localparam int CFG_HGT_W  = 13;
  localparam int CFG_RAD_W  = 2;
  localparam int ROW_LIMIT  = 4096;

  localparam logic [CFG_WID_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [CFG_HGT_W-1:0] RST_HEIGHT = 13'd480;
  localparam logic [CFG_RAD_W-1:0] RST_RADIUS = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_WINDOW_RADIUS = 2'd2
  } cfg_idx_t;

  // control from the sequencer to the sort array
  typedef struct packed {
    logic clear;
    logic insert;
    logic shift;
  } sort_ctl_t;

endpackage

// ===== rtl/cwm_sorter.sv =====
// ----------------------------------------------------------------------------
// cwm_sorter
// Insertion sort array: values enter one per cycle while insert is set and stay in ascending
// order; shifting toward the head drops the smallest value.
// ----------------------------------------------------------------------------
module cwm_sorter #(
  parameter int PIXEL_BITS = cwm_pkg::DEF_PIXEL_BITS,
  parameter int DEPTH      = 49
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cwm_pkg::sort_ctl_t    ctl,
  input  logic [PIXEL_BITS-1:0] din,
  output logic [PIXEL_BITS-1:0] head
);

  logic [PIXEL_BITS-1:0] s_r   [DEPTH];
  logic [DEPTH-1:0]      vld_r;
  logic [DEPTH-1:0]      ins;

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    logic prev_ins;
    logic prev_vld;
    logic [PIXEL_BITS-1:0] prev_s;
    logic [PIXEL_BITS-1:0] next_s;
    logic next_vld;

    if (i == 0) begin : g_first
      assign prev_ins = 1'b0;
      assign prev_vld = 1'b1;
      assign prev_s   = din;
    end else begin : g_rest
      assign prev_ins = ins[i-1];
      assign prev_vld = vld_r[i-1];
      assign prev_s   = s_r[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_s   = s_r[i];
      assign next_vld = 1'b0;
    end else begin : g_mid
      assign next_s   = s_r[i+1];
      assign next_vld = vld_r[i+1];
    end

    assign ins[i] = !vld_r[i] || (din < s_r[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (ctl.clear) begin
        vld_r[i] <= 1'b0;
      end else if (ctl.insert) begin
        vld_r[i] <= vld_r[i] | prev_vld;
      end else if (ctl.shift) begin
        vld_r[i] <= next_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.insert && ins[i]) begin
        s_r[i] <= prev_ins ? prev_s : din;
      end else if (ctl.shift) begin
        s_r[i] <= next_s;
      end
    end
  end

  assign head = s_r[0];

  if (DEPTH > 1) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      vld_r[1] |-> (s_r[0] <= s_r[1]))
      else $error("sort array out of order");
  end

  a_shift_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.shift |-> vld_r[0])
    else $error("shift of empty sort array");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.insert && ctl.shift))
    else $error("insert and shift together");

endmodule

// ===== rtl/clipped_window_median_filter.sv =====
// ----------------------------------------------------------------------------
// clipped_window_median_filter
// Raster-order median filter over one plane; windows are clipped to the image.
//
//  channel  direction  handshake          payload
//  cfg      in         cfg_we             cfg_index, cfg_wdata
//  in       in         in_valid/in_ready  in_command, in_pixel_value
//  out      out        out_valid/out_ready median, column, row, frame_end
//
//  An item with no result goes from S_CHECK back to S_IDLE. An item with a
//  result passes S_CHECK, S_READ, S_LAST and S_DONE, n the clipped window
//  size (up to 49): the window is read from the line memory one pixel a cycle
//  into the sort array, which then shifts n/2 times. No clearing pass after
//  reset. The output register lets the next item in while a result waits; a
//  stalled result holds the sequencer only when the next one is ready to load.
// ----------------------------------------------------------------------------
module clipped_window_median_filter #(
  parameter int MAX_WIDTH  = cwm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = cwm_pkg::DEF_MAX_RADIUS,
  parameter int PIXEL_BITS = cwm_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cwm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cwm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_command,
  input  logic [PIXEL_BITS-1:0]             in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [PIXEL_BITS-1:0]             out_median_value,
  output logic [cwm_pkg::OUT_COL_W-1:0]     out_column,
  output logic [cwm_pkg::ROW_W-1:0]         out_row,
  output logic                              out_frame_end
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int SIDE   = 2 * MAX_RADIUS + 1;
  localparam int DEPTH  = SIDE * SIDE;
  localparam int SLOT_W = $clog2(SIDE + 1);
  localparam int MEM_D  = (1 << SLOT_W) * (1 << CW);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int RW     = cwm_pkg::ROW_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_READ  = 5'b00100,
    S_LAST  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [cwm_pkg::CFG_WID_W-1:0] cfg_w_r;
  logic [cwm_pkg::CFG_HGT_W-1:0] cfg_h_r;
  logic [cwm_pkg::CFG_RAD_W-1:0] cfg_r_r;

  logic [CW-1:0]  in_col_r, emit_col_r;
  logic [RW-1:0]  in_row_r, emit_row_r;
  logic           in_done_r;

  logic [CW-1:0]  x_r, c0_r, c1_r;
  logic [RW-1:0]  y_r, r1_r;
  logic           rd_pend_r;
  logic           shifting_r;
  logic [CNT_W-1:0] cnt_r, sh_r;

  logic [PIXEL_BITS-1:0] mem [MEM_D];
  logic [PIXEL_BITS-1:0] rd_data_r;

  logic                  out_valid_r, out_last_r;
  logic [PIXEL_BITS-1:0] out_med_r;
  logic [CW-1:0]         out_col_r;
  logic [RW-1:0]         out_row_r;

  // effective configuration
  logic [CW-1:0]                wm1;
  logic [RW-1:0]                hm1;
  logic [cwm_pkg::RAD_W-1:0]    r_eff;
  logic [31:0]                  w32, h32, r32;

  always_comb begin
    w32 = 32'(cfg_w_r);
    h32 = 32'(cfg_h_r);
    r32 = 32'(cfg_r_r);
    if (w32 == 32'd0)                    wm1 = '0;
    else if (w32 > 32'(MAX_WIDTH))       wm1 = CW'(MAX_WIDTH - 1);
    else                                 wm1 = CW'(w32 - 32'd1);
    if (h32 == 32'd0)                    hm1 = '0;
    else if (h32 > 32'(cwm_pkg::ROW_LIMIT)) hm1 = RW'(cwm_pkg::ROW_LIMIT - 1);
    else                                 hm1 = RW'(h32 - 32'd1);
    if (r32 > 32'(MAX_RADIUS))           r_eff = cwm_pkg::RAD_W'(MAX_RADIUS);
    else                                 r_eff = cwm_pkg::RAD_W'(r32);
  end

  // window bounds of the next output position
  logic [RW:0]   row_sum;
  logic [CW:0]   col_sum;
  logic [RW-1:0] need_row, win_r0;
  logic [CW-1:0] need_col, win_c0;
  logic          out_ok;

  always_comb begin
    row_sum  = {1'b0, emit_row_r} + (RW+1)'(r_eff);
    col_sum  = {1'b0, emit_col_r} + (CW+1)'(r_eff);
    need_row = (row_sum > {1'b0, hm1}) ? hm1 : row_sum[RW-1:0];
    need_col = (col_sum > {1'b0, wm1}) ? wm1 : col_sum[CW-1:0];
    win_r0   = (emit_row_r >= RW'(r_eff)) ? emit_row_r - RW'(r_eff) : '0;
    win_c0   = ({1'b0, emit_col_r} >= (CW+1)'(r_eff)) ? emit_col_r - CW'(r_eff) : '0;
    out_ok   = in_done_r || (in_row_r > need_row) ||
               ((in_row_r == need_row) && (in_col_r > need_col));
  end

  logic acc, store, load_out, out_free, last_emit, read_end;
  cwm_pkg::sort_ctl_t sort_ctl;
  logic [PIXEL_BITS-1:0] sort_head;

  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign store     = acc && !in_command && !in_done_r;
  assign out_free  = !out_valid_r || out_ready;
  assign load_out  = (state_r == S_DONE) && out_free && !sort_ctl.shift;
  assign last_emit = (emit_row_r == hm1) && (emit_col_r == wm1);
  assign read_end  = (x_r == c1_r) && (y_r == r1_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (acc) state_nxt = S_CHECK;
      S_CHECK: state_nxt = out_ok ? S_READ : S_IDLE;
      S_READ:  if (read_end) state_nxt = S_LAST;
      S_LAST:  state_nxt = S_DONE;
      S_DONE:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // S_DONE first shifts the sort array down to the median, then loads it
  assign sort_ctl.clear  = (state_r == S_CHECK) && out_ok;
  assign sort_ctl.insert = rd_pend_r;
  assign sort_ctl.shift  = (state_r == S_DONE) && (sh_r != (cnt_r >> 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_w_r     <= cwm_pkg::RST_WIDTH;
      cfg_h_r     <= cwm_pkg::RST_HEIGHT;
      cfg_r_r     <= cwm_pkg::RST_RADIUS;
      in_col_r    <= '0;
      in_row_r    <= '0;
      emit_col_r  <= '0;
      emit_row_r  <= '0;
      in_done_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sh_r        <= '0;
      shifting_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == S_READ);
      shifting_r <= sort_ctl.shift;

      if (store) begin
        if (in_col_r == wm1) begin
          in_col_r <= '0;
          if (in_row_r == hm1) begin
            in_row_r  <= '0;
            in_done_r <= 1'b1;
          end else begin
            in_row_r <= in_row_r + 1'b1;
          end
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end

      if (sort_ctl.clear) begin
        cnt_r <= '0;
        sh_r  <= '0;
      end else begin
        if (sort_ctl.insert) cnt_r <= cnt_r + 1'b1;
        if (sort_ctl.shift)  sh_r  <= sh_r + 1'b1;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load_out && !sort_ctl.shift) begin
        if (last_emit) begin
          in_col_r   <= '0;
          in_row_r   <= '0;
          emit_col_r <= '0;
          emit_row_r <= '0;
          in_done_r  <= 1'b0;
        end else if (emit_col_r == wm1) begin
          emit_col_r <= '0;
          emit_row_r <= emit_row_r + 1'b1;
        end else begin
          emit_col_r <= emit_col_r + 1'b1;
        end
      end

      if (cfg_we) begin
        unique case (cfg_index)
          cwm_pkg::CFG_IMAGE_WIDTH:   cfg_w_r <= cfg_wdata[cwm_pkg::CFG_WID_W-1:0];
          cwm_pkg::CFG_IMAGE_HEIGHT:  cfg_h_r <= cfg_wdata[cwm_pkg::CFG_HGT_W-1:0];
          cwm_pkg::CFG_WINDOW_RADIUS: cfg_r_r <= cfg_wdata[cwm_pkg::CFG_RAD_W-1:0];
          default: ;
        endcase
        if (cfg_index inside {cwm_pkg::CFG_IMAGE_WIDTH, cwm_pkg::CFG_IMAGE_HEIGHT,
                              cwm_pkg::CFG_WINDOW_RADIUS}) begin
          in_col_r   <= '0;
          in_row_r   <= '0;
          emit_col_r <= '0;
          emit_row_r <= '0;
          in_done_r  <= 1'b0;
        end
      end
    end
  end

  // the sequencer stays in S_DONE until shifting is finished and the output is free
  logic done_state;
  assign done_state = (state_r == S_DONE) && !sort_ctl.shift;

  // window scan and output payload
  always_ff @(posedge clk) begin
    if (state_r == S_CHECK) begin
      y_r  <= win_r0;
      x_r  <= win_c0;
      r1_r <= need_row;
      c0_r <= win_c0;
      c1_r <= need_col;
    end else if (state_r == S_READ) begin
      if (x_r == c1_r) begin
        x_r <= c0_r;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
    if (load_out && done_state) begin
      out_med_r  <= sort_head;
      out_col_r  <= emit_col_r;
      out_row_r  <= emit_row_r;
      out_last_r <= last_emit;
    end
  end

  // line memory: one row slot per recent row, addressed by row slot and column
  always_ff @(posedge clk) begin
    if (store) mem[{in_row_r[SLOT_W-1:0], in_col_r}] <= in_pixel_value;
    if (state_r == S_READ) rd_data_r <= mem[{y_r[SLOT_W-1:0], x_r}];
  end

  cwm_sorter #(
    .PIXEL_BITS (PIXEL_BITS),
    .DEPTH      (DEPTH)
  ) u_sorter (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (sort_ctl),
    .din   (rd_data_r),
    .head  (sort_head)
  );

  logic [31:0] col_ext;
  assign col_ext          = 32'(out_col_r);
  assign out_valid        = out_valid_r;
  assign out_median_value = out_med_r;
  assign out_column       = col_ext[cwm_pkg::OUT_COL_W-1:0];
  assign out_row          = out_row_r;
  assign out_frame_end    = out_last_r;

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && done_state) |-> out_free)
    else $error("result loaded over a pending transfer");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (cnt_r <= CNT_W'(DEPTH) && cnt_r != '0))
    else $error("window count out of range");

  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    shifting_r |-> !rd_pend_r)
    else $error("shift overlaps window read");

endmodule
